[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every edge outside reset
`define CRTM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define CRTM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CRTM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRTM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[hdl/crtm_pkg.sv]
package crtm_pkg;

    // sizing defaults
    localparam int DEFAULT_MAX_RULES   = 64;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    // reset value of the default level, 1.0 in q16.16
    localparam logic [31:0] DEFAULT_LEVEL_RESET = 32'h0001_0000;

    // minute clamp and the star bound
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [6:0] STAR       = 7'h7F;

    // command codes
    localparam logic [1:0] CMD_WRITE_RANGE = 2'd0;
    localparam logic [1:0] CMD_WRITE_VALUE = 2'd1;
    localparam logic [1:0] CMD_EVALUATE    = 2'd2;

    // range select codes
    localparam logic [2:0] SEL_MINUTE   = 3'd0;
    localparam logic [2:0] SEL_HOUR     = 3'd1;
    localparam logic [2:0] SEL_MONTHDAY = 3'd2;
    localparam logic [2:0] SEL_MONTH    = 3'd3;
    localparam logic [2:0] SEL_WEEKDAY  = 3'd4;

    // configuration register indexes
    localparam logic [0:0] CFG_RULE_COUNT    = 1'b0;
    localparam logic [0:0] CFG_DEFAULT_LEVEL = 1'b1;

    // classified operation kinds
    typedef enum logic [1:0] {
        OP_RANGE = 2'd0,
        OP_VALUE = 2'd1,
        OP_EVAL  = 2'd2
    } op_kind_t;

    // one classified request as it sits in the queue
    typedef struct packed {
        op_kind_t    kind;
        logic [2:0]  sel;
        logic [5:0]  idx;
        logic [6:0]  lo;
        logic [6:0]  hi;
        logic [31:0] value;
        logic        mark;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } op_t;

    // back end status seen by the top level
    typedef struct packed {
        logic walking;
        logic out_load;
    } back_stat_t;

endpackage

[hdl/crtm_front.sv]
module crtm_front #(
    parameter int MAX_RULES = crtm_pkg::DEFAULT_MAX_RULES
) (
    input  logic                push,
    input  logic [1:0]          cmd,
    input  logic [5:0]          entry_index,
    input  logic [2:0]          range_select,
    input  logic signed [6:0]   range_lo,
    input  logic signed [6:0]   range_hi,
    input  logic signed [31:0]  rule_value,
    input  logic                group_last,
    input  logic [3:0]          time_month,
    input  logic [4:0]          time_day,
    input  logic [2:0]          time_weekday,
    input  logic [4:0]          time_hour,
    input  logic [5:0]          time_minute,
    input  logic                q_full,
    output logic                q_push,
    output crtm_pkg::op_t       q_din
);

    logic accept;
    logic idx_ok;
    logic keep;

    // a request is taken whenever the queue has room
    assign accept = push && !q_full;
    assign idx_ok = 32'(entry_index) < 32'(MAX_RULES);

    // classify: clamp the minute, drop writes off the table, unknown selects and unknown commands
    always_comb
    begin
        q_din         = '0;
        q_din.sel     = range_select;
        q_din.idx     = entry_index;
        q_din.lo      = range_lo;
        q_din.hi      = range_hi;
        q_din.value   = rule_value;
        q_din.mark    = group_last;
        q_din.month   = time_month;
        q_din.day     = time_day;
        q_din.weekday = time_weekday;
        q_din.hour    = time_hour;
        q_din.minute  = (time_minute > crtm_pkg::MINUTE_MAX) ? crtm_pkg::MINUTE_MAX
                                                             : time_minute;
        keep          = 1'b0;
        case (cmd)
            crtm_pkg::CMD_WRITE_RANGE:
            begin
                q_din.kind = crtm_pkg::OP_RANGE;
                keep       = idx_ok && (range_select <= crtm_pkg::SEL_WEEKDAY);
            end
            crtm_pkg::CMD_WRITE_VALUE:
            begin
                q_din.kind = crtm_pkg::OP_VALUE;
                keep       = idx_ok;
            end
            crtm_pkg::CMD_EVALUATE:
            begin
                q_din.kind = crtm_pkg::OP_EVAL;
                keep       = 1'b1;
            end
            default:
            begin
                q_din.kind = crtm_pkg::OP_EVAL;
                keep       = 1'b0;
            end
        endcase
    end

    assign q_push = accept && keep;

endmodule

[hdl/crtm_queue.sv]
module crtm_queue #(
    parameter int DEPTH = crtm_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  crtm_pkg::op_t din,
    output logic          full,
    input  logic          pop,
    output crtm_pkg::op_t dout,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crtm_pkg::op_t fifo_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = fifo_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem[wr_ptr_reg] <= din;
        end
    end

endmodule

[hdl/crtm_back.sv]
module crtm_back #(
    parameter int MAX_RULES = crtm_pkg::DEFAULT_MAX_RULES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crtm_pkg::op_t        q_dout,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic [6:0]           rule_count,
    input  logic [31:0]          default_level,
    output logic                 out_valid,
    output logic [31:0]          out_value,
    output logic                 out_matched,
    input  logic                 pop,
    output crtm_pkg::back_stat_t stat
);

    localparam int ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W  = $clog2(MAX_RULES + 1);
    localparam int LIM_W  = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // rule table
    logic [13:0] minute_mem   [MAX_RULES];
    logic [13:0] hour_mem     [MAX_RULES];
    logic [13:0] monthday_mem [MAX_RULES];
    logic [13:0] month_mem    [MAX_RULES];
    logic [13:0] weekday_mem  [MAX_RULES];
    logic [31:0] value_mem    [MAX_RULES];
    logic        mark_mem     [MAX_RULES];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             chk_valid_reg, chk_valid_next;
    logic             chk_last_reg, chk_last_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_value_reg, out_value_next;
    logic             out_matched_reg, out_matched_next;

    // time of the evaluation in flight
    logic [3:0]  t_month_reg, t_month_next;
    logic [4:0]  t_day_reg, t_day_next;
    logic [2:0]  t_weekday_reg, t_weekday_next;
    logic [4:0]  t_hour_reg, t_hour_next;
    logic [5:0]  t_minute_reg, t_minute_next;

    // running result
    logic [31:0] acc_value_reg, acc_value_next;
    logic        acc_matched_reg, acc_matched_next;
    logic        group_done_reg, group_done_next;

    // registered table read
    logic [13:0] minute_rd_reg, hour_rd_reg, monthday_rd_reg, month_rd_reg, weekday_rd_reg;
    logic [31:0] value_rd_reg;
    logic        mark_rd_reg;

    logic [ADDR_W+5:0]  wr_addr_ext;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [13:0]        wr_range;
    logic               wr_range_en;
    logic               wr_value_en;
    logic               rd_en;
    logic [LIM_W-1:0]   rc_ext;
    logic [LIM_W-1:0]   rc_lim;
    logic               day_ok;
    logic               hit;
    logic               out_load;

    function automatic logic is_any(input logic [13:0] r);
        return (r[6:0] == crtm_pkg::STAR) && (r[13:7] == crtm_pkg::STAR);
    endfunction

    function automatic logic no_star(input logic [13:0] r);
        return (r[6:0] != crtm_pkg::STAR) && (r[13:7] != crtm_pkg::STAR);
    endfunction

    function automatic logic in_range(input logic [13:0] r, input logic [5:0] t);
        logic signed [6:0] lo;
        logic signed [6:0] hi;
        logic signed [6:0] tv;
        lo = r[6:0];
        hi = r[13:7];
        tv = {1'b0, t};
        if (is_any(r))
        begin
            return 1'b1;
        end
        else if (!no_star(r))
        begin
            return 1'b0;
        end
        return (lo <= tv) && (tv <= hi);
    endfunction

    // table addressing
    assign wr_addr_ext = {{ADDR_W{1'b0}}, q_dout.idx};
    assign wr_addr     = wr_addr_ext[ADDR_W-1:0];
    assign wr_range    = {q_dout.hi, q_dout.lo};
    assign rd_addr     = rd_idx_reg[ADDR_W-1:0];
    assign q_pop       = (state_reg == ST_IDLE) && !q_empty;
    assign wr_range_en = q_pop && (q_dout.kind == crtm_pkg::OP_RANGE);
    assign wr_value_en = q_pop && (q_dout.kind == crtm_pkg::OP_VALUE);
    assign rd_en       = (state_reg == ST_WALK) && (rd_idx_reg != n_reg);

    // walk length, clipped to the table size
    assign rc_ext = LIM_W'(rule_count);
    assign rc_lim = (rc_ext > LIM_W'(MAX_RULES)) ? LIM_W'(MAX_RULES) : rc_ext;

    // match test on the entry read last cycle
    always_comb
    begin
        if (is_any(weekday_rd_reg) && no_star(monthday_rd_reg))
        begin
            day_ok = in_range(monthday_rd_reg, {1'b0, t_day_reg});
        end
        else if (is_any(monthday_rd_reg) && no_star(weekday_rd_reg))
        begin
            day_ok = in_range(weekday_rd_reg, {3'b000, t_weekday_reg});
        end
        else
        begin
            day_ok = 1'b1;
        end
        hit = in_range(month_rd_reg, {2'b00, t_month_reg}) && day_ok &&
              in_range(hour_rd_reg, {1'b0, t_hour_reg}) &&
              in_range(minute_rd_reg, t_minute_reg);
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || pop);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        rd_idx_next      = rd_idx_reg;
        n_next           = n_reg;
        chk_valid_next   = rd_en;
        chk_last_next    = rd_en && (rd_idx_reg == n_reg - CNT_W'(1));
        t_month_next     = t_month_reg;
        t_day_next       = t_day_reg;
        t_weekday_next   = t_weekday_reg;
        t_hour_next      = t_hour_reg;
        t_minute_next    = t_minute_reg;
        acc_value_next   = acc_value_reg;
        acc_matched_next = acc_matched_reg;
        group_done_next  = group_done_reg;
        out_valid_next   = out_valid_reg && !pop;
        out_value_next   = out_value_reg;
        out_matched_next = out_matched_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && (q_dout.kind == crtm_pkg::OP_EVAL))
                begin
                    n_next           = rc_lim[CNT_W-1:0];
                    rd_idx_next      = '0;
                    t_month_next     = q_dout.month;
                    t_day_next       = q_dout.day;
                    t_weekday_next   = q_dout.weekday;
                    t_hour_next      = q_dout.hour;
                    t_minute_next    = q_dout.minute;
                    acc_value_next   = default_level;
                    acc_matched_next = 1'b0;
                    group_done_next  = 1'b0;
                    state_next       = (rc_lim == '0) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (chk_valid_reg)
                begin
                    if (!group_done_reg && hit)
                    begin
                        acc_value_next   = value_rd_reg;
                        acc_matched_next = 1'b1;
                    end
                    group_done_next = mark_rd_reg ? 1'b0 : (group_done_reg || hit);
                    if (chk_last_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = acc_value_reg;
                    out_matched_next = acc_matched_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
            chk_last_reg  <= chk_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        t_month_reg     <= t_month_next;
        t_day_reg       <= t_day_next;
        t_weekday_reg   <= t_weekday_next;
        t_hour_reg      <= t_hour_next;
        t_minute_reg    <= t_minute_next;
        acc_value_reg   <= acc_value_next;
        acc_matched_reg <= acc_matched_next;
        group_done_reg  <= group_done_next;
        out_value_reg   <= out_value_next;
        out_matched_reg <= out_matched_next;
    end

    // table write port
    always_ff @(posedge clk)
    begin
        if (wr_range_en)
        begin
            case (q_dout.sel)
                crtm_pkg::SEL_MINUTE:   minute_mem[wr_addr]   <= wr_range;
                crtm_pkg::SEL_HOUR:     hour_mem[wr_addr]     <= wr_range;
                crtm_pkg::SEL_MONTHDAY: monthday_mem[wr_addr] <= wr_range;
                crtm_pkg::SEL_MONTH:    month_mem[wr_addr]    <= wr_range;
                crtm_pkg::SEL_WEEKDAY:  weekday_mem[wr_addr]  <= wr_range;
                default:
                begin
                end
            endcase
        end
        if (wr_value_en)
        begin
            value_mem[wr_addr] <= q_dout.value;
            mark_mem[wr_addr]  <= q_dout.mark;
        end
    end

    // table read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            minute_rd_reg   <= minute_mem[rd_addr];
            hour_rd_reg     <= hour_mem[rd_addr];
            monthday_rd_reg <= monthday_mem[rd_addr];
            month_rd_reg    <= month_mem[rd_addr];
            weekday_rd_reg  <= weekday_mem[rd_addr];
            value_rd_reg    <= value_mem[rd_addr];
            mark_rd_reg     <= mark_mem[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_matched   = out_matched_reg;
    assign stat.walking  = (state_reg == ST_WALK);
    assign stat.out_load = out_load;

endmodule

[hdl/cron_rule_table_matcher.sv]
// channel   handshake          payload
// input     push / full        cmd, entry_index, range_select, range_lo, range_hi,
//                              rule_value, group_last, time_month, time_day,
//                              time_weekday, time_hour, time_minute
// result    empty / pop        schedule_value, rule_matched
// config    cfg_we             cfg_index, cfg_data
//
// a table write is done in the back end as it is popped from the queue; an evaluation
// walks min(rule_count, MAX_RULES) entries, or goes straight to its result when no entry is
// walked, with the table walk of one entry per cycle through the single registered read port.
// a short request queue lets requests be taken while an evaluation walks.
// reset clears control state only; table contents are undefined until written.
// a waiting result holds in the output register while later requests queue up.
`include "assert_macros.svh"

module cron_rule_table_matcher #(
    parameter int MAX_RULES   = crtm_pkg::DEFAULT_MAX_RULES,
    parameter int QUEUE_DEPTH = crtm_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         cmd,
    input  logic [5:0]         entry_index,
    input  logic [2:0]         range_select,
    input  logic signed [6:0]  range_lo,
    input  logic signed [6:0]  range_hi,
    input  logic signed [31:0] rule_value,
    input  logic               group_last,
    input  logic [3:0]         time_month,
    input  logic [4:0]         time_day,
    input  logic [2:0]         time_weekday,
    input  logic [4:0]         time_hour,
    input  logic [5:0]         time_minute,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] schedule_value,
    output logic               rule_matched,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    crtm_pkg::op_t        q_din;
    crtm_pkg::op_t        q_dout;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    logic                 out_valid;
    logic [31:0]          out_value;
    crtm_pkg::back_stat_t stat;

    logic [6:0]  rule_count_reg;
    logic [31:0] default_level_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg    <= '0;
            default_level_reg <= crtm_pkg::DEFAULT_LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                crtm_pkg::CFG_RULE_COUNT:    rule_count_reg    <= cfg_data[6:0];
                crtm_pkg::CFG_DEFAULT_LEVEL: default_level_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front end: accept and classify
    crtm_front #(
        .MAX_RULES (MAX_RULES)
    ) u_front (
        .push         (push),
        .cmd          (cmd),
        .entry_index  (entry_index),
        .range_select (range_select),
        .range_lo     (range_lo),
        .range_hi     (range_hi),
        .rule_value   (rule_value),
        .group_last   (group_last),
        .time_month   (time_month),
        .time_day     (time_day),
        .time_weekday (time_weekday),
        .time_hour    (time_hour),
        .time_minute  (time_minute),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_din        (q_din)
    );

    // request queue between front and back
    crtm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // back end: table and walker
    crtm_back #(
        .MAX_RULES (MAX_RULES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_dout        (q_dout),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .rule_count    (rule_count_reg),
        .default_level (default_level_reg),
        .out_valid     (out_valid),
        .out_value     (out_value),
        .out_matched   (rule_matched),
        .pop           (pop),
        .stat          (stat)
    );

    assign full           = q_full;
    assign empty          = !out_valid;
    assign schedule_value = out_value;

    // checks
    `CRTM_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, q_push && q_full, "queue push while full")
    `CRTM_ASSERT(a_no_pop_while_walking, clk, rst_n, stat.walking |-> !q_pop, "queue pop during walk")
    `CRTM_ASSERT(a_load_into_free_slot, clk, rst_n, stat.out_load |-> (empty || pop), "result overwritten")
    `CRTM_ASSERT(a_load_shows_result, clk, rst_n, stat.out_load |=> !empty, "loaded result not shown")

endmodule

[tb/cron_rule_table_matcher_tb.sv]
`timescale 1ns / 1ps

module cron_rule_table_matcher_tb;
    import crtm_pkg::*;

    localparam int RULE_SLOTS = DEFAULT_MAX_RULES;
    // worst case for queued table writes and a full walk to drain
    localparam int SETTLE_CYCLES = 450;
    localparam int TIMEOUT_NS = 2_000_000;

    // request codes the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] SEL_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] SEL_LAST_UNUSED = 3'd7;

    localparam logic signed [31:0] LEVEL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LEVEL_MIN = 32'sh8000_0000;

    typedef struct {
        logic [1:0]         op;
        logic [5:0]         slot;
        logic [2:0]         sel;
        logic signed [6:0]  lo;
        logic signed [6:0]  hi;
        logic signed [31:0] level;
        logic               mark;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [2:0]         wday;
        logic [4:0]         hour;
        logic [5:0]         minute;
    } sched_req_t;

    typedef struct {
        logic signed [6:0] lo;
        logic signed [6:0] hi;
    } bounds_t;

    typedef struct {
        logic signed [31:0] level;
        logic               hit;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push;
    logic full;
    logic [1:0] cmd;
    logic [5:0] entry_index;
    logic [2:0] range_select;
    logic signed [6:0] range_lo;
    logic signed [6:0] range_hi;
    logic signed [31:0] rule_value;
    logic group_last;
    logic [3:0] time_month;
    logic [4:0] time_day;
    logic [2:0] time_weekday;
    logic [4:0] time_hour;
    logic [5:0] time_minute;
    logic empty;
    logic pop;
    logic signed [31:0] schedule_value;
    logic rule_matched;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [31:0] cfg_data;

    // shadow copy of the rule table and registers
    bounds_t rule_bounds [0:4][0:RULE_SLOTS-1];
    logic signed [31:0] rule_levels [0:RULE_SLOTS-1];
    logic rule_closes [0:RULE_SLOTS-1];
    logic [6:0] active_rules = 7'd0;
    logic signed [31:0] fallback_level = DEFAULT_LEVEL_RESET;

    outcome_t expected_outcomes [$];
    bit sender_gaps = 1'b0;
    bit receiver_stalls = 1'b0;
    int long_hold = 0;
    int mismatches = 0;

    cron_rule_table_matcher uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .entry_index    (entry_index),
        .range_select   (range_select),
        .range_lo       (range_lo),
        .range_hi       (range_hi),
        .rule_value     (rule_value),
        .group_last     (group_last),
        .time_month     (time_month),
        .time_day       (time_day),
        .time_weekday   (time_weekday),
        .time_hour      (time_hour),
        .time_minute    (time_minute),
        .empty          (empty),
        .pop            (pop),
        .schedule_value (schedule_value),
        .rule_matched   (rule_matched),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // range helpers
    function automatic bit bound_star(bounds_t b);
        return b.lo == STAR && b.hi == STAR;
    endfunction

    function automatic bit bound_fixed(bounds_t b);
        return b.lo != STAR && b.hi != STAR;
    endfunction

    function automatic bit bound_hit(bounds_t b, int t);
        int lo;
        int hi;
        lo = $signed(b.lo);
        hi = $signed(b.hi);
        if (bound_star(b))
            return 1'b1;
        if (!bound_fixed(b))
            return 1'b0;
        return lo <= t && t <= hi;
    endfunction

    // walk the shadow table for one evaluation
    function automatic outcome_t schedule_lookup(sched_req_t r);
        outcome_t res;
        int n;
        int minute;
        bit closed;
        bit hit;
        bounds_t dr;
        bounds_t wr;
        res.level = fallback_level;
        res.hit = 1'b0;
        closed = 1'b0;
        minute = r.minute;
        if (minute > MINUTE_MAX)
            minute = MINUTE_MAX;
        n = (active_rules > RULE_SLOTS) ? RULE_SLOTS : active_rules;
        for (int i = 0; i < n; i++)
        begin
            dr = rule_bounds[SEL_MONTHDAY][i];
            wr = rule_bounds[SEL_WEEKDAY][i];
            hit = bound_hit(rule_bounds[SEL_MONTH][i], r.month)
                && bound_hit(rule_bounds[SEL_HOUR][i], r.hour)
                && bound_hit(rule_bounds[SEL_MINUTE][i], minute);
            // day test follows the star pattern of the two day ranges
            if (bound_star(wr) && bound_fixed(dr))
                hit = hit && bound_hit(dr, r.day);
            else if (bound_star(dr) && bound_fixed(wr))
                hit = hit && bound_hit(wr, r.wday);
            if (!closed && hit)
            begin
                res.level = rule_levels[i];
                res.hit = 1'b1;
                closed = 1'b1;
            end
            if (rule_closes[i])
                closed = 1'b0;
        end
        return res;
    endfunction

    // update the shadow state for one accepted request
    function automatic void apply_request(sched_req_t r);
        case (r.op)
            CMD_WRITE_RANGE:
            begin
                if (r.sel <= SEL_WEEKDAY)
                begin
                    rule_bounds[r.sel][r.slot].lo = r.lo;
                    rule_bounds[r.sel][r.slot].hi = r.hi;
                end
            end
            CMD_WRITE_VALUE:
            begin
                rule_levels[r.slot] = r.level;
                rule_closes[r.slot] = r.mark;
            end
            CMD_EVALUATE:
                expected_outcomes.push_back(schedule_lookup(r));
            default:
                ;
        endcase
    endfunction

    // request builders; unused fields carry random bits
    function automatic sched_req_t make_req(logic [1:0] op);
        sched_req_t r;
        r.op = op;
        r.slot = 6'($urandom_range(0, RULE_SLOTS - 1));
        r.sel = 3'($urandom_range(0, 7));
        r.lo = 7'($urandom());
        r.hi = 7'($urandom());
        r.level = $urandom();
        r.mark = 1'($urandom_range(0, 1));
        r.month = 4'($urandom_range(0, 12));
        r.day = 5'($urandom_range(0, 31));
        r.wday = 3'($urandom_range(0, 7));
        r.hour = 5'($urandom_range(0, 24));
        r.minute = 6'($urandom_range(0, 63));
        return r;
    endfunction

    function automatic sched_req_t range_write(int slot, logic [2:0] sel,
                                               logic signed [6:0] lo,
                                               logic signed [6:0] hi);
        sched_req_t r;
        r = make_req(CMD_WRITE_RANGE);
        r.slot = 6'(slot);
        r.sel = sel;
        r.lo = lo;
        r.hi = hi;
        return r;
    endfunction

    function automatic sched_req_t value_write(int slot, logic signed [31:0] level,
                                               logic mark);
        sched_req_t r;
        r = make_req(CMD_WRITE_VALUE);
        r.slot = 6'(slot);
        r.level = level;
        r.mark = mark;
        return r;
    endfunction

    function automatic sched_req_t time_eval(int month, int day, int wday, int hour,
                                             int minute);
        sched_req_t r;
        r = make_req(CMD_EVALUATE);
        r.month = 4'(month);
        r.day = 5'(day);
        r.wday = 3'(wday);
        r.hour = 5'(hour);
        r.minute = 6'(minute);
        return r;
    endfunction

    // random bounds for one field, mostly well formed
    function automatic bounds_t random_bounds(logic [2:0] sel);
        bounds_t b;
        int top;
        int a;
        int c;
        int pick;
        case (sel)
            SEL_MINUTE:   top = 60;
            SEL_HOUR:     top = 24;
            SEL_MONTHDAY: top = 31;
            SEL_MONTH:    top = 12;
            default:      top = 7;
        endcase
        pick = $urandom_range(0, 99);
        a = $urandom_range(0, top);
        c = $urandom_range(0, top);
        if (pick < 35)
        begin
            b.lo = STAR;
            b.hi = STAR;
        end
        else if (pick < 39)
        begin
            b.lo = STAR;
            b.hi = 7'(a);
        end
        else if (pick < 43)
        begin
            b.lo = 7'(a);
            b.hi = STAR;
        end
        else if (pick < 46)
        begin
            b.lo = 7'($urandom());
            b.hi = 7'($urandom());
        end
        else if (pick < 52)
        begin
            // descending, never passes unless equal
            b.lo = 7'((a > c) ? a : c);
            b.hi = 7'((a > c) ? c : a);
        end
        else
        begin
            b.lo = 7'((a > c) ? c : a);
            b.hi = 7'((a > c) ? a : c);
        end
        return b;
    endfunction

    // send one request and wait for it to be taken
    task automatic send_request(sched_req_t r);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        push <= 1'b1;
        cmd <= r.op;
        entry_index <= r.slot;
        range_select <= r.sel;
        range_lo <= r.lo;
        range_hi <= r.hi;
        rule_value <= r.level;
        group_last <= r.mark;
        time_month <= r.month;
        time_day <= r.day;
        time_weekday <= r.wday;
        time_hour <= r.hour;
        time_minute <= r.minute;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_request(r);
    endtask

    // full rewrite of one table entry with random content
    task automatic load_random_rule(int slot);
        bounds_t b;
        for (int s = SEL_MINUTE; s <= SEL_WEEKDAY; s++)
        begin
            b = random_bounds(3'(s));
            send_request(range_write(slot, 3'(s), b.lo, b.hi));
        end
        send_request(value_write(slot, $urandom(), $urandom_range(0, 9) < 3));
    endtask

    // stop sending and wait for every expected result
    task automatic wait_drain();
        push <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // also let queued table writes finish before a register write
    task automatic wait_settled();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [0:0] index, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_RULE_COUNT)
            active_rules = data[6:0];
        else
            fallback_level = data;
        @(posedge clk);
    endtask

    // upper data bits are random, only the low seven count
    task automatic set_rule_count(int count);
        logic [31:0] data;
        data = $urandom();
        data[6:0] = 7'(count);
        write_register(CFG_RULE_COUNT, data);
    endtask

    // empty table after reset gives the reset default
    task automatic test_empty_table();
        send_request(make_req(CMD_EVALUATE));
        send_request(make_req(CMD_UNUSED));
        send_request(make_req(CMD_EVALUATE));
    endtask

    // every entry written before any walk can reach it
    task automatic test_table_fill();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        for (int slot = 0; slot < RULE_SLOTS; slot++)
            load_random_rule(slot);
        wait_settled();
        set_rule_count(RULE_SLOTS);
    endtask

    // minute clamp, day test patterns, grouping, ignored requests, long count
    task automatic test_directed_cases();
        wait_settled();
        set_rule_count(2);
        write_register(CFG_DEFAULT_LEVEL, 32'h0);
        // entry 0: day of month path, minute pinned to the clamp value
        send_request(range_write(0, SEL_MONTH, STAR, STAR));
        send_request(range_write(0, SEL_MONTHDAY, 1, 31));
        send_request(range_write(0, SEL_WEEKDAY, STAR, STAR));
        send_request(range_write(0, SEL_HOUR, 0, 24));
        send_request(range_write(0, SEL_MINUTE, 59, 59));
        send_request(value_write(0, LEVEL_MAX, 1'b0));
        // entry 1: weekday path, same group as entry 0
        send_request(range_write(1, SEL_MONTH, 0, 12));
        send_request(range_write(1, SEL_MONTHDAY, STAR, STAR));
        send_request(range_write(1, SEL_WEEKDAY, 3, 3));
        send_request(range_write(1, SEL_HOUR, STAR, STAR));
        send_request(range_write(1, SEL_MINUTE, STAR, STAR));
        send_request(value_write(1, LEVEL_MIN, 1'b1));
        // minute above the clamp at the field extremes
        send_request(time_eval(12, 31, 7, 24, 63));
        send_request(time_eval(12, 5, 0, 0, 60));
        // day of month fails, weekday rule takes over, then nothing matches
        send_request(time_eval(12, 0, 3, 0, 59));
        send_request(time_eval(0, 0, 4, 0, 0));
        // unknown select and unknown command leave the table alone
        send_request(range_write(0, SEL_LAST_UNUSED, STAR, STAR));
        send_request(make_req(CMD_UNUSED));
        send_request(time_eval(12, 31, 7, 24, 63));
        // first hit in a group wins, a later group overrides
        send_request(time_eval(12, 5, 3, 10, 59));
        send_request(value_write(0, LEVEL_MAX, 1'b1));
        send_request(time_eval(12, 5, 3, 10, 59));
        // rule count past the table walks the whole table
        wait_settled();
        set_rule_count(127);
        send_request(make_req(CMD_EVALUATE));
        send_request(make_req(CMD_EVALUATE));
    endtask

    // random mix over several register settings
    task automatic test_random_traffic();
        int phase_rules [6];
        logic [31:0] phase_levels [6];
        int sent;
        int pick;
        bounds_t b;
        phase_rules = '{1, 64, 127, $urandom_range(2, 63), 0, 65};
        phase_levels = '{LEVEL_MAX, LEVEL_MIN, $urandom(), 32'h0, $urandom(),
                         DEFAULT_LEVEL_RESET};
        for (int p = 0; p < 6; p++)
        begin
            wait_settled();
            set_rule_count(phase_rules[p]);
            write_register(CFG_DEFAULT_LEVEL, phase_levels[p]);
            sender_gaps = ($urandom_range(0, 2) != 0);
            receiver_stalls = ($urandom_range(0, 2) != 0);
            sent = 0;
            while (sent < 30)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    send_request(make_req(CMD_EVALUATE));
                    sent++;
                end
                else if (pick < 72)
                begin
                    b = random_bounds(3'(pick % 5));
                    send_request(range_write($urandom_range(0, RULE_SLOTS - 1),
                                             3'(pick % 5), b.lo, b.hi));
                    sent++;
                end
                else if (pick < 80)
                begin
                    send_request(make_req(CMD_WRITE_VALUE));
                    sent++;
                end
                else if (pick < 92)
                begin
                    load_random_rule($urandom_range(0, RULE_SLOTS - 1));
                    sent += 6;
                end
                else if (pick < 96)
                    send_request(make_req(CMD_UNUSED));
                else
                begin
                    send_request(range_write($urandom_range(0, RULE_SLOTS - 1),
                                             3'($urandom_range(SEL_FIRST_UNUSED,
                                                               SEL_LAST_UNUSED)),
                                             7'($urandom()), 7'($urandom())));
                end
            end
        end
    endtask

    // result side blocked long enough for the input side to fill and stall
    task automatic test_backpressure();
        wait_settled();
        set_rule_count(RULE_SLOTS);
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        long_hold = 400;
        for (int n = 0; n < 30; n++)
            send_request(make_req(CMD_EVALUATE));
        // pause until everything is back, then resume
        wait_drain();
        for (int n = 0; n < 10; n++)
            send_request(make_req(CMD_EVALUATE));
    endtask

    // closing stretch with no idling on either side
    task automatic test_steady_flow();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        for (int n = 0; n < 40; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_request(make_req(CMD_WRITE_VALUE));
            else
                send_request(make_req(CMD_EVALUATE));
        end
    endtask

    // result side: random pop, compare against the oldest expectation
    initial
    begin : result_checker
        int hold_left;
        outcome_t want;
        hold_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %h matched %b",
                                 schedule_value, rule_matched);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (schedule_value !== want.level || rule_matched !== want.hit)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h %b, got %h %b",
                                     want.level, want.hit, schedule_value, rule_matched);
                    end
                end
            end
            if (!rst_n)
                pop <= 1'b0;
            else if (long_hold > 0)
            begin
                pop <= 1'b0;
                long_hold--;
            end
            else if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (receiver_stalls && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                hold_left = $urandom_range(1, 12) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        push <= 1'b0;
        cmd <= CMD_WRITE_RANGE;
        entry_index <= '0;
        range_select <= SEL_MINUTE;
        range_lo <= '0;
        range_hi <= '0;
        rule_value <= '0;
        group_last <= 1'b0;
        time_month <= '0;
        time_day <= '0;
        time_weekday <= '0;
        time_hour <= '0;
        time_minute <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_RULE_COUNT;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_table_fill();
        test_directed_cases();
        test_random_traffic();
        test_backpressure();
        test_steady_flow();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/crtm_pkg.sv
hdl/crtm_front.sv
hdl/crtm_queue.sv
hdl/crtm_back.sv
hdl/cron_rule_table_matcher.sv
tb/cron_rule_table_matcher_tb.sv
